>>> rtl/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg
// Shared field widths and request codes for the sector bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sba_pkg;

   localparam int SECTOR_W  = 11;   // sector number field
   localparam int DIRTY_W   = 4;    // dirty row field

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_MARK  = 1'b1;

endpackage

`default_nettype wire

>>> rtl/sba_if.sv
// ----------------------------------------------------------------------------
// sba_req_if / sba_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sba_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [sba_pkg::SECTOR_W-1:0]  sector_in;

   modport source (output valid, op, sector_in, input ready);
   modport sink   (input valid, op, sector_in, output ready);
endinterface

interface sba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sba_pkg::SECTOR_W-1:0]  sector_out;
   logic                          full_res;
   logic [sba_pkg::DIRTY_W-1:0]   dirty_row;
   logic                          row_changed;

   modport source (output valid, sector_out, full_res, dirty_row, row_changed, input ready);
   modport sink   (input valid, sector_out, full_res, dirty_row, row_changed, output ready);
endinterface

`default_nettype wire

>>> rtl/sba_find_free.sv
// ----------------------------------------------------------------------------
// sba_find_free
// Priority encoder: lowest clear bit of one bitmap row.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_find_free #(
   parameter int WIDTH = 128,
   parameter int IDX_W = 7
) (
   input  wire logic [WIDTH-1:0] word,
   output      logic             found,
   output      logic [IDX_W-1:0] idx
);

   always_comb begin
      found = 1'b0;
      idx   = '0;
      // walk downward so the lowest free bit wins
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (!word[i]) begin
            found = 1'b1;
            idx   = IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/sector_bitmap_allocator_core.sv
// Allocate reads the bitmap rows in order from row 0 until a clear bit is found or the
//   last row is full; mark-used first finds the row index by repeated subtraction of
//   BITS_PER_ROW, then sets the bit. The response waits until the output register is free.
// One request in flight; the next is taken in the cycle after the response is loaded.
// Reset (synchronous) clears per-row valid bits at once: every sector reads free.
// ----------------------------------------------------------------------------
// sector_bitmap_allocator_core
// First-fit sector allocator over a row-organized used/free bitmap memory.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_bitmap_allocator_core #(
   parameter int NUM_ROWS     = 16,
   parameter int BITS_PER_ROW = 128
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sba_req_if.sink    req_ch,
   sba_rsp_if.source  rsp_ch
);
   import sba_pkg::*;

   localparam int          ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int          OFF_W    = $clog2(BITS_PER_ROW);
   localparam int unsigned TOTAL    = NUM_ROWS * BITS_PER_ROW;
   localparam int          BASE_W   = $clog2(TOTAL + 1);
   localparam logic [ROW_W-1:0]    ROW_LAST = ROW_W'(NUM_ROWS - 1);
   localparam logic [SECTOR_W-1:0] BPR_S    = SECTOR_W'(BITS_PER_ROW);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_CHK  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic                    op_ff, op_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [BASE_W-1:0]       base_ff, base_in;
   logic [SECTOR_W-1:0]     resid_ff, resid_in;
   logic [SECTOR_W-1:0]     res_sector_ff, res_sector_in;
   logic                    res_full_ff, res_full_in;
   logic [DIRTY_W-1:0]      res_row_ff, res_row_in;
   logic                    res_chg_ff, res_chg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SECTOR_W-1:0]     rsp_sector_ff;
   logic                    rsp_full_ff;
   logic [DIRTY_W-1:0]      rsp_row_ff;
   logic                    rsp_chg_ff;
   logic                    rsp_load;

   logic [BITS_PER_ROW-1:0] mem_ff [NUM_ROWS];
   logic [NUM_ROWS-1:0]     row_vld_ff;
   logic [BITS_PER_ROW-1:0] rd_data_ff;
   logic                    rd_vld_ff;

   logic [BITS_PER_ROW-1:0] word;
   logic [BITS_PER_ROW-1:0] wr_data;
   logic                    wr_en;
   logic                    ff_found;
   logic [OFF_W-1:0]        ff_idx;
   logic [OFF_W-1:0]        bit_off;

   assign req_ch.ready = (state_ff == ST_IDLE);

   // rows never written read as all free
   assign word    = rd_vld_ff ? rd_data_ff : '0;
   assign bit_off = (op_ff == OP_MARK) ? resid_ff[OFF_W-1:0] : ff_idx;
   assign wr_data = word | (BITS_PER_ROW'(1) << bit_off);

   sba_find_free #(
      .WIDTH (BITS_PER_ROW),
      .IDX_W (OFF_W)
   ) u_find (
      .word  (word),
      .found (ff_found),
      .idx   (ff_idx)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      resid_in      = resid_ff;
      res_sector_in = res_sector_ff;
      res_full_in   = res_full_ff;
      res_row_in    = res_row_ff;
      res_chg_in    = res_chg_ff;
      wr_en         = 1'b0;
      rsp_load      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in         = req_ch.op;
               row_in        = '0;
               base_in       = '0;
               resid_in      = req_ch.sector_in;
               res_sector_in = req_ch.sector_in;
               res_full_in   = 1'b0;
               res_row_in    = '0;
               res_chg_in    = 1'b0;
               if (req_ch.op == OP_MARK) begin
                  if (32'(req_ch.sector_in) >= TOTAL) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_DIV;
                  end
               end else begin
                  state_in = ST_CHK;
               end
            end
         end
         ST_DIV: begin
            if (resid_ff >= BPR_S) begin
               resid_in = resid_ff - BPR_S;
               row_in   = row_ff + ROW_W'(1);
            end else begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (op_ff == OP_MARK || ff_found) begin
               wr_en      = 1'b1;
               res_row_in = DIRTY_W'(row_ff);
               res_chg_in = 1'b1;
               if (op_ff == OP_ALLOC) begin
                  res_sector_in = SECTOR_W'(base_ff + BASE_W'(ff_idx));
               end
               state_in = ST_DONE;
            end else if (row_ff == ROW_LAST) begin
               res_sector_in = '0;
               res_full_in   = 1'b1;
               state_in      = ST_DONE;
            end else begin
               row_in  = row_ff + ROW_W'(1);
               base_in = base_ff + BASE_W'(BITS_PER_ROW);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= row_vld_ff[row_in];
         if (wr_en) begin
            row_vld_ff[row_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      row_ff        <= row_in;
      base_ff       <= base_in;
      resid_ff      <= resid_in;
      res_sector_ff <= res_sector_in;
      res_full_ff   <= res_full_in;
      res_row_ff    <= res_row_in;
      res_chg_ff    <= res_chg_in;
      if (rsp_load) begin
         rsp_sector_ff <= res_sector_ff;
         rsp_full_ff   <= res_full_ff;
         rsp_row_ff    <= res_row_ff;
         rsp_chg_ff    <= res_chg_ff;
      end
   end

   // bitmap row memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[row_ff] <= wr_data;
      end
      rd_data_ff <= mem_ff[row_in];
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.sector_out  = rsp_sector_ff;
   assign rsp_ch.full_res    = rsp_full_ff;
   assign rsp_ch.dirty_row   = rsp_row_ff;
   assign rsp_ch.row_changed = rsp_chg_ff;

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.full_res) |-> (!rsp_ch.row_changed && rsp_ch.sector_out == '0))
      else $error("full response carries a sector or a dirty row");

   a_alloc_scan: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.op == OP_ALLOC) |=> (state_ff == ST_CHK))
      else $error("allocate did not start the row scan");

   a_write_done: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (state_ff == ST_DONE && res_chg_ff))
      else $error("row write not followed by a changed-row response");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK) |-> (row_ff <= ROW_LAST))
      else $error("row index past the bitmap");

endmodule

`default_nettype wire
